// ===== rtl/lphs_pkg.sv =====
// Package for the linear-probing hash set: sizes, command, status, slot mark and FSM state codes.
// Used by linear_probe_hash_set; depends on nothing else.
package lphs_pkg;

   localparam int CAPACITY   = 1024;
   localparam int KEY_BITS   = 64;
   localparam int HASH_BITS  = 64;
   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int TOTAL_BITS = 11;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_MISSING = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MARK_EMPTY   = 2'd0,
      MARK_LIVE    = 2'd1,
      MARK_DELETED = 2'd2
   } mark_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_PROBE,
      S_FIN
   } state_type;

endpackage

// ===== rtl/linear_probe_hash_set.sv =====
// Linear-probing hash set: one item at a time, probing one slot per cycle.
// A new item is accepted only after the previous one has finished and its result has been
// registered; remove always walks all CAPACITY slots and the unused command probes no slot.
// A finished item waits in S_FIN while an earlier result is still pending on rsp_ready.
// Reset: synchronous; afterwards a clearing pass over all CAPACITY slots empties the slot
// marks while req_ready stays low.
module linear_probe_hash_set (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_cmd,
   input  logic [63:0]                      req_item_key,
   input  logic [63:0]                      req_key_hash,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [lphs_pkg::TOTAL_BITS-1:0]  rsp_entry_total
);
   import lphs_pkg::*;

   mark_type                slot_marks_mem [CAPACITY];
   logic [KEY_BITS-1:0]     slot_keys_mem  [CAPACITY];

   state_type               state_ff, state_in;
   logic [IDX_BITS-1:0]     idx_ff, idx_in;
   logic [IDX_BITS-1:0]     n_ff, n_in;
   logic [1:0]              cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic                    hit_ff, hit_in;
   status_type              status_ff, status_in;
   logic [CNT_BITS-1:0]     live_count_ff, live_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [TOTAL_BITS-1:0]   rsp_total_ff, rsp_total_in;

   mark_type                mark_rd_ff;
   logic [KEY_BITS-1:0]     key_rd_ff;

   logic [IDX_BITS-1:0]     rd_addr;
   logic                    mark_we;
   logic [IDX_BITS-1:0]     mark_waddr;
   mark_type                mark_wdata;
   logic                    key_we;
   logic [IDX_BITS-1:0]     start_idx;
   logic [IDX_BITS-1:0]     nxt_idx;
   logic                    last_slot;
   logic                    slot_live;
   logic                    slot_match;

   always_ff @(posedge clock) begin
      if (mark_we) begin
         slot_marks_mem[mark_waddr] <= mark_wdata;
      end
      mark_rd_ff <= slot_marks_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         slot_keys_mem[idx_ff] <= key_ff;
      end
      key_rd_ff <= slot_keys_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         idx_ff        <= '0;
         live_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         live_count_ff <= live_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      n_ff          <= n_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      hit_ff        <= hit_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
   end

   always_comb begin
      start_idx  = IDX_BITS'(req_key_hash % HASH_BITS'(CAPACITY));
      nxt_idx    = (idx_ff == IDX_BITS'(CAPACITY - 1)) ? '0 : idx_ff + 1'b1;
      last_slot  = (n_ff == IDX_BITS'(CAPACITY - 1));
      slot_live  = (mark_rd_ff == MARK_LIVE);
      slot_match = slot_live && (key_rd_ff == key_ff);

      state_in      = state_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      hit_in        = hit_ff;
      status_in     = status_ff;
      live_count_in = live_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;
      rd_addr       = nxt_idx;
      mark_we       = 1'b0;
      mark_waddr    = idx_ff;
      mark_wdata    = MARK_EMPTY;
      key_we        = 1'b0;
      req_ready     = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            mark_we    = 1'b1;
            mark_wdata = MARK_EMPTY;
            idx_in     = nxt_idx;
            if (idx_ff == IDX_BITS'(CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = start_idx;
            if (req_valid) begin
               cmd_in  = req_cmd;
               key_in  = req_item_key[KEY_BITS-1:0];
               hit_in  = 1'b0;
               n_in    = '0;
               idx_in  = start_idx;
               if (req_cmd == CMD_UNUSED) begin
                  status_in = ST_MISSING;
                  state_in  = S_FIN;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            idx_in = nxt_idx;
            n_in   = n_ff + 1'b1;
            case (cmd_ff)
               CMD_INSERT: begin
                  if (!slot_live) begin
                     mark_we       = 1'b1;
                     mark_wdata    = MARK_LIVE;
                     key_we        = 1'b1;
                     live_count_in = live_count_ff + 1'b1;
                     status_in     = ST_OK;
                     state_in      = S_FIN;
                  end else if (last_slot) begin
                     status_in = ST_FULL;
                     state_in  = S_FIN;
                  end
               end
               CMD_LOOKUP: begin
                  if (mark_rd_ff == MARK_EMPTY) begin
                     status_in = ST_MISSING;
                     state_in  = S_FIN;
                  end else if (slot_match) begin
                     status_in = ST_OK;
                     state_in  = S_FIN;
                  end else if (last_slot) begin
                     status_in = ST_MISSING;
                     state_in  = S_FIN;
                  end
               end
               CMD_REMOVE: begin
                  if (slot_match) begin
                     mark_we    = 1'b1;
                     mark_wdata = MARK_DELETED;
                     hit_in     = 1'b1;
                     if (live_count_ff != '0) begin
                        live_count_in = live_count_ff - 1'b1;
                     end
                  end
                  if (last_slot) begin
                     status_in = (hit_ff || slot_match) ? ST_OK : ST_MISSING;
                     state_in  = S_FIN;
                  end
               end
               default: begin
                  status_in = ST_MISSING;
                  state_in  = S_FIN;
               end
            endcase
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_total_in  = TOTAL_BITS'(live_count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_total = rsp_total_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      live_count_ff <= CNT_BITS'(CAPACITY))
      else $error("live count above capacity");

   a_insert_free: assert property (@(posedge clock) disable iff (reset)
      key_we |-> (mark_rd_ff != MARK_LIVE) && (state_ff == S_PROBE))
      else $error("insert overwrote a live slot");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      key_we |=> live_count_ff == $past(live_count_ff) + 1'b1)
      else $error("insert did not advance live count");

   a_count_in_probe: assert property (@(posedge clock) disable iff (reset)
      (live_count_ff != $past(live_count_ff)) |-> ($past(state_ff) == S_PROBE))
      else $error("live count changed outside a probe");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FIN))
      else $error("item presented without finishing an operation");

endmodule
